### rtl/mhs_pkg.sv
// Package for the streaming 64-bit hash block: mixing constants, queue entry,
// word classes, sequencer states and the shared xor-shift helper.
// No dependencies.
package mhs_pkg;

    localparam logic [63:0] MIX_M      = 64'hc6a4a7935bd1e995;
    localparam int unsigned MIX_R      = 47;
    localparam logic [63:0] SEED_RESET = 64'hBEEFCAFEDEADE621;

    typedef enum logic [1:0] {
        K_NONE,
        K_TAIL,
        K_FULL
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] word;
        logic [31:0] len;
        logic        first;
        logic        last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic push;
        logic in_msg;
    } t_front_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN,
        ST_DATA,
        ST_K1,
        ST_K2,
        ST_ACC,
        ST_LAST,
        ST_FIN,
        ST_EMIT
    } t_back_state;

    function automatic logic [63:0] xorshift(input logic [63:0] h);
        return h ^ (h >> MIX_R);
    endfunction

endpackage

### rtl/mhs_stream_if.sv
// Valid/ready channel interfaces for message words in and hash values out.
// No dependencies.
interface mhs_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  bytes_valid;
    logic        first_item;
    logic        last_item;
    logic [31:0] message_length;

    modport source (
        output valid, data_word, bytes_valid, first_item, last_item, message_length,
        input  ready
    );
    modport sink (
        input  valid, data_word, bytes_valid, first_item, last_item, message_length,
        output ready
    );
endinterface

interface mhs_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

### rtl/mhs_front.sv
// Front end: accepts message words, tracks message framing, drops stray words,
// masks tail bytes and classifies each word for the queue. Uses mhs_pkg, mhs_in_if.
module mhs_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mhs_in_if.sink                i_in,
    input  mhs_pkg::t_q_stat      i_q_stat,
    output mhs_pkg::t_entry       o_entry,
    output mhs_pkg::t_front_stat  o_stat
);

    logic r_in_msg;
    logic n_in_msg;
    logic accept;
    logic keep;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign keep       = i_in.first_item || r_in_msg;
    assign n_in_msg   = accept ? (keep && !i_in.last_item) : r_in_msg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
        end else begin
            r_in_msg <= n_in_msg;
        end
    end

    always_comb begin
        o_entry.word  = i_in.data_word;
        o_entry.len   = i_in.message_length;
        o_entry.first = i_in.first_item;
        o_entry.last  = i_in.last_item;
        if (i_in.bytes_valid == 4'd0) begin
            o_entry.kind = mhs_pkg::K_NONE;
        end else if (i_in.bytes_valid inside {[4'd1:4'd7]}) begin
            o_entry.kind = mhs_pkg::K_TAIL;
            for (int i = 0; i < 8; i++) begin
                o_entry.word[8*i +: 8] = i_in.data_word[8*i +: 8]
                                       & {8{4'(i) < i_in.bytes_valid}};
            end
        end else begin
            o_entry.kind = mhs_pkg::K_FULL;
        end
    end

    assign o_stat.push   = accept && keep;
    assign o_stat.in_msg = r_in_msg;

endmodule

### rtl/mhs_queue.sv
// Small register queue between the front end and the hash sequencer.
// Uses mhs_pkg.
module mhs_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mhs_pkg::t_entry   i_entry,
    input  logic              i_pop,
    output mhs_pkg::t_entry   o_head,
    output mhs_pkg::t_q_stat  o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mhs_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;

    assign n_wr_ptr = !i_push ? r_wr_ptr
                    : (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = !i_pop ? r_rd_ptr
                    : (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

### rtl/mhs_mul.sv
// Multiply of a 64-bit operand by the mixing constant, modulo 2^64,
// built from three registered 32x32 partial products. Uses mhs_pkg.
module mhs_mul (
    input  logic        i_clk,
    input  logic [63:0] i_operand,
    output logic [63:0] o_product
);

    localparam logic [31:0] ML = mhs_pkg::MIX_M[31:0];
    localparam logic [31:0] MH = mhs_pkg::MIX_M[63:32];

    logic [63:0] r_ll;
    logic [31:0] r_hl;
    logic [31:0] r_lh;
    logic [63:0] n_ll;
    logic [31:0] n_hl;
    logic [31:0] n_lh;

    assign n_ll = i_operand[31:0] * ML;
    assign n_hl = i_operand[63:32] * ML;
    assign n_lh = i_operand[31:0] * MH;

    always_ff @(posedge i_clk) begin
        r_ll <= n_ll;
        r_hl <= n_hl;
        r_lh <= n_lh;
    end

    assign o_product = r_ll + {r_hl + r_lh, 32'd0};

endmodule

### rtl/mhs_back.sv
// Hash sequencer: seeds, mixes and finalizes the accumulator for each queued
// word through one shared multiplier, and holds the result register.
// Uses mhs_pkg, mhs_mul, mhs_out_if.
module mhs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [63:0]       i_seed,
    input  mhs_pkg::t_entry   i_head,
    input  mhs_pkg::t_q_stat  i_q_stat,
    output logic              o_pop,
    mhs_out_if.source         o_out
);

    mhs_pkg::t_back_state r_state;
    mhs_pkg::t_back_state n_state;
    logic [63:0] r_acc;
    logic [63:0] n_acc;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [63:0] r_hash;
    logic [63:0] n_hash;
    logic [63:0] operand;
    logic [63:0] product;
    logic        out_free;
    logic        do_data;
    logic        do_last;

    mhs_mul u_mul (
        .i_clk     (i_clk),
        .i_operand (operand),
        .o_product (product)
    );

    assign out_free = !r_out_valid || o_out.ready;
    assign do_data  = (r_state == mhs_pkg::ST_DATA)
                   || (r_state == mhs_pkg::ST_IDLE && !i_q_stat.empty && !i_head.first);
    assign do_last  = (r_state == mhs_pkg::ST_LAST)
                   || (do_data && i_head.kind == mhs_pkg::K_NONE);

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_hash      = r_hash;
        n_out_valid = r_out_valid && !o_out.ready;
        operand     = '0;
        o_pop       = 1'b0;
        case (r_state)
            mhs_pkg::ST_IDLE: begin
                if (!i_q_stat.empty && i_head.first) begin
                    operand = {32'd0, i_head.len};
                    n_state = mhs_pkg::ST_LEN;
                end
            end
            mhs_pkg::ST_LEN: begin
                n_acc   = i_seed ^ product;
                n_state = mhs_pkg::ST_DATA;
            end
            mhs_pkg::ST_DATA: begin
            end
            mhs_pkg::ST_K1: begin
                operand = mhs_pkg::xorshift(product);
                n_state = mhs_pkg::ST_K2;
            end
            mhs_pkg::ST_K2: begin
                operand = r_acc ^ product;
                n_state = mhs_pkg::ST_ACC;
            end
            mhs_pkg::ST_ACC: begin
                n_acc   = product;
                n_state = mhs_pkg::ST_LAST;
            end
            mhs_pkg::ST_LAST: begin
            end
            mhs_pkg::ST_FIN: begin
                n_acc   = product;
                n_state = mhs_pkg::ST_EMIT;
            end
            mhs_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_hash      = mhs_pkg::xorshift(r_acc);
                    o_pop       = 1'b1;
                    n_state     = mhs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mhs_pkg::ST_IDLE;
            end
        endcase

        if (do_data) begin
            case (i_head.kind)
                mhs_pkg::K_FULL: begin
                    operand = i_head.word;
                    n_state = mhs_pkg::ST_K1;
                end
                mhs_pkg::K_TAIL: begin
                    operand = r_acc ^ i_head.word;
                    n_state = mhs_pkg::ST_ACC;
                end
                default: begin
                end
            endcase
        end

        if (do_last) begin
            if (i_head.last) begin
                operand = mhs_pkg::xorshift(r_acc);
                n_state = mhs_pkg::ST_FIN;
            end else begin
                o_pop   = 1'b1;
                n_state = mhs_pkg::ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mhs_pkg::ST_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_hash;

endmodule

### rtl/murmur_hash_64a_stream.sv
// Streaming 64-bit multiply-xor hash (64A variant), top level.
// Input channel i_in: one transaction per 64-bit little-endian message word,
// with bytes_valid, first_item/last_item framing and message_length on the
// first word. A word outside a message is accepted and dropped.
// Output channel o_out: one transaction carrying hash_value per message, after
// the word marked last_item.
// Configuration: i_cfg_we/i_cfg_wdata write the 64-bit seed; write only while idle.
// Words pass a QUEUE_DEPTH-entry queue into a sequencer that runs every step
// through one 64-bit multiplier, so the sequencer sets the rate; it takes a new
// word from the queue only when done with the last. A full word runs the K1, K2
// and ACC steps, a tail word the ACC step and an empty word none; a first word
// adds the length product, a last word adds the final mix (FIN, EMIT).
// The front keeps accepting words while the queue has room, also while a hash
// waits in the output register; a stalled receiver holds the hash and
// eventually fills the queue, which drops i_in.ready.
// Synchronous reset clears framing, queue, sequencer, output valid and restores
// the default seed.
module murmur_hash_64a_stream #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,
    mhs_in_if.sink      i_in,
    mhs_out_if.source   o_out
);

    logic [63:0]          r_seed;
    mhs_pkg::t_entry      q_entry;
    mhs_pkg::t_entry      q_head;
    mhs_pkg::t_q_stat     q_stat;
    mhs_pkg::t_front_stat f_stat;
    logic                 q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= mhs_pkg::SEED_RESET;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    mhs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_entry  (q_entry),
        .o_stat   (f_stat)
    );

    mhs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_stat.push),
        .i_entry (q_entry),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    mhs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_seed   (r_seed),
        .i_head   (q_head),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !f_stat.push)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_drop_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !i_in.first_item && !f_stat.in_msg) |-> !f_stat.push)
        else $error("word outside a message was queued");

    a_out_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(q_pop))
        else $error("hash presented without retiring a queued word");

endmodule
